FILE: rtl/core/iee_pkg.sv
// package for the infix expression evaluator core
// holds operator codes, character classes, status codes and engine states; no dependencies
`default_nettype none

package iee_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QP_W        = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_PAREN = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_DIVZERO   = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_MALFORMED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        K_NONE  = 3'd0,
        K_DIGIT = 3'd1,
        K_LPAR  = 3'd2,
        K_RPAR  = 3'd3,
        K_OPER  = 3'd4
    } kind_t;

    // classified request passed from front to back
    typedef struct packed {
        kind_t      kind;
        op_t        op;
        logic [3:0] digit;
        logic       last;
    } token_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_REDUCE,
        S_DIV,
        S_WRITE,
        S_FLUSH,
        S_EMIT
    } state_t;

    function automatic logic [1:0] prec(input op_t op);
        return (op == OP_MUL || op == OP_DIV) ? 2'd2 : 2'd1;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/infix_expression_evaluator_core.sv
// infix expression evaluator: characters are taken one at a time through the stack
// engine; each reduction adds a reduce step (divide: one quotient bit per cycle in the
// iterative divider); a last character adds the flush reductions and the result emit.
// a 4-entry token queue decouples character intake from the stack engine.
// rst_n is asynchronous active low and empties both stacks and the queue.
`default_nettype none

module infix_expression_evaluator_core
    import iee_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // [31:0] value, [33:32] status, zero fill
);

    logic   q_valid, q_ready;
    token_t q_tok;
    logic [31:0] value;
    logic [1:0]  status;

    iee_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_ch    (s_tdata),
        .s_last  (s_tlast),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_tok   (q_tok)
    );

    iee_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_tok    (q_tok),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_value  (value),
        .m_status (status)
    );

    assign m_tdata = {6'd0, status, value};

endmodule

`default_nettype wire

FILE: rtl/core/iee_front.sv
// front end: accepts characters, classifies them and queues tokens
// depends on iee_pkg
`default_nettype none

module iee_front
    import iee_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   s_valid,
    output logic        s_ready,
    input  wire logic [7:0] s_ch,
    input  wire logic   s_last,
    output logic        q_valid,
    input  wire logic   q_ready,
    output token_t      q_tok
);

    token_t          mem [QUEUE_DEPTH];
    logic [QP_W-1:0] wr_reg, rd_reg;
    logic [QP_W:0]   cnt_reg;
    token_t          tok;
    logic            push, pop;

    always_comb
    begin
        tok.kind  = K_NONE;
        tok.op    = OP_ADD;
        tok.digit = 4'(s_ch - CH_ZERO);
        tok.last  = s_last;
        if (s_ch >= CH_ZERO && s_ch <= CH_NINE)
            tok.kind = K_DIGIT;
        else
        begin
            case (s_ch)
                CH_LPAR:  tok.kind = K_LPAR;
                CH_RPAR:  tok.kind = K_RPAR;
                CH_PLUS:  begin tok.kind = K_OPER; tok.op = OP_ADD; end
                CH_MINUS: begin tok.kind = K_OPER; tok.op = OP_SUB; end
                CH_STAR:  begin tok.kind = K_OPER; tok.op = OP_MUL; end
                CH_SLASH: begin tok.kind = K_OPER; tok.op = OP_DIV; end
                default:  tok.kind = K_NONE;
            endcase
        end
    end

    assign s_ready = (cnt_reg != (QP_W+1)'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_tok   = mem[rd_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (QP_W+1)'(push) - (QP_W+1)'(pop);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/iee_div.sv
// iterative signed divider, one quotient bit per cycle, truncates toward zero
// depends on iee_pkg
`default_nettype none

module iee_div
    import iee_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic             done,
    output logic [31:0]      q
);

    logic [31:0] rem_reg, quo_reg, den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg, neg_reg;
    logic [32:0] trial;
    logic [31:0] rem_sh;

    assign rem_sh = {rem_reg[30:0], quo_reg[31]};
    assign trial  = {1'b0, rem_sh} - {1'b0, den_reg};
    assign done   = busy_reg && (cnt_reg == 6'd0);
    assign q      = neg_reg ? (32'd0 - quo_reg) : quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= a[31] ? (32'd0 - a) : a;
            den_reg <= b[31] ? (32'd0 - b) : b;
            neg_reg <= a[31] ^ b[31];
        end
        else if (busy_reg && cnt_reg != 6'd0)
        begin
            if (!trial[32])
                rem_reg <= trial[31:0];
            else
                rem_reg <= rem_sh;
            quo_reg <= {quo_reg[30:0], ~trial[32]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'd32;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'd0)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/iee_back.sv
// back end: two stacks, reduction sequencer and result register
// depends on iee_pkg and iee_div
`default_nettype none

module iee_back
    import iee_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_valid,
    output logic        q_ready,
    input  wire token_t q_tok,
    output logic        m_valid,
    input  wire logic   m_ready,
    output logic [31:0] m_value,
    output logic [1:0]  m_status
);

    logic [31:0] opnd_mem [STACK_DEPTH];
    op_t         oper_mem [STACK_DEPTH];

    state_t     state_reg, state_next;
    token_t     tok_reg;
    logic [CNT_W-1:0] ocnt_reg, pcnt_reg;
    status_t    err_reg;
    logic [31:0] a_reg, b_reg, r_reg;
    op_t        rop_reg;
    logic       out_valid_reg;
    logic [31:0] out_value_reg;
    logic [1:0]  out_status_reg;

    logic [31:0] top_b, top_a;
    op_t         top_op;
    logic        div_start, div_done;
    logic [31:0] div_q;
    logic [31:0] prod;

    assign top_b  = opnd_mem[SP_W'(ocnt_reg - 1'b1)];
    assign top_a  = opnd_mem[SP_W'(ocnt_reg - 2'd2)];
    assign top_op = oper_mem[SP_W'(pcnt_reg - 1'b1)];
    assign prod   = a_reg * b_reg;

    iee_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (a_reg),
        .b     (b_reg),
        .done  (div_done),
        .q     (div_q)
    );

    // reduction legality on the current tops
    logic can_reduce;
    assign can_reduce = (pcnt_reg != '0) && (ocnt_reg >= CNT_W'(2))
                        && (top_op != OP_PAREN);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (q_valid)
                    state_next = S_DISPATCH;
            S_DISPATCH:
                if (err_reg != ST_OK)
                    state_next = tok_reg.last ? S_FLUSH : S_IDLE;
                else
                begin
                    case (tok_reg.kind)
                        K_RPAR:
                            if (pcnt_reg == '0 || top_op == OP_PAREN)
                                state_next = tok_reg.last ? S_FLUSH : S_IDLE;
                            else
                                state_next = can_reduce ? S_REDUCE : S_FLUSH;
                        K_OPER:
                            if (pcnt_reg != '0 && top_op != OP_PAREN
                                && prec(top_op) >= prec(tok_reg.op))
                                state_next = can_reduce ? S_REDUCE : S_FLUSH;
                            else
                                state_next = tok_reg.last ? S_FLUSH : S_IDLE;
                        default:
                            state_next = tok_reg.last ? S_FLUSH : S_IDLE;
                    endcase
                    if ((tok_reg.kind == K_RPAR || tok_reg.kind == K_OPER)
                        && state_next == S_FLUSH && !tok_reg.last)
                        state_next = S_IDLE;
                end
            S_REDUCE:
                state_next = (rop_reg == OP_DIV) ? ((b_reg == '0) ? S_DISPATCH : S_DIV)
                                                 : S_WRITE;
            S_DIV:
                if (div_done)
                    state_next = S_WRITE;
            S_WRITE:
                state_next = S_DISPATCH;
            S_FLUSH:
                if (err_reg != ST_OK || pcnt_reg == '0)
                    state_next = S_EMIT;
                else if (can_reduce)
                    state_next = S_REDUCE;
                else
                    state_next = S_EMIT;
            S_EMIT:
                if (!out_valid_reg)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    assign q_ready   = (state_reg == S_IDLE);
    assign div_start = (state_reg == S_REDUCE) && (rop_reg == OP_DIV) && (b_reg != '0);
    assign m_valid   = out_valid_reg;
    assign m_value   = out_value_reg;
    assign m_status  = out_status_reg;

    // dispatch flag tracks whether the pending token was fully handled
    logic handled_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_valid)
            tok_reg <= q_tok;
        if ((state_reg == S_DISPATCH || state_reg == S_FLUSH) && state_next == S_REDUCE)
        begin
            a_reg   <= top_a;
            b_reg   <= top_b;
            rop_reg <= top_op;
        end
        if (state_reg == S_REDUCE)
        begin
            case (rop_reg)
                OP_ADD:  r_reg <= a_reg + b_reg;
                OP_SUB:  r_reg <= a_reg - b_reg;
                default: r_reg <= prod;
            endcase
        end
        if (state_reg == S_DIV && div_done)
            r_reg <= div_q;
        if (state_reg == S_WRITE)
            opnd_mem[SP_W'(ocnt_reg)] <= r_reg;
        if (state_reg == S_DISPATCH && err_reg == ST_OK && !handled_reg)
        begin
            if (tok_reg.kind == K_DIGIT && ocnt_reg != CNT_W'(STACK_DEPTH))
                opnd_mem[SP_W'(ocnt_reg)] <= {28'd0, tok_reg.digit};
            if (tok_reg.kind == K_LPAR && pcnt_reg != CNT_W'(STACK_DEPTH))
                oper_mem[SP_W'(pcnt_reg)] <= OP_PAREN;
            if (tok_reg.kind == K_OPER && state_next != S_REDUCE
                && (state_next != S_FLUSH || tok_reg.last)
                && pcnt_reg != CNT_W'(STACK_DEPTH)
                && !(pcnt_reg != '0 && top_op != OP_PAREN
                     && prec(top_op) >= prec(tok_reg.op)))
                oper_mem[SP_W'(pcnt_reg)] <= tok_reg.op;
        end
    end

    status_t err_flush;
    always_comb
    begin
        err_flush = err_reg;
        if (err_reg == ST_OK && pcnt_reg != '0)
            err_flush = ST_MALFORMED;
        else if (err_reg == ST_OK && ocnt_reg != CNT_W'(1))
            err_flush = ST_MALFORMED;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ocnt_reg       <= '0;
            pcnt_reg       <= '0;
            err_reg        <= ST_OK;
            handled_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_status_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && m_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == S_IDLE)
                handled_reg <= 1'b0;

            if (state_reg == S_DISPATCH && err_reg == ST_OK && !handled_reg)
            begin
                case (tok_reg.kind)
                    K_DIGIT:
                    begin
                        handled_reg <= 1'b1;
                        if (ocnt_reg == CNT_W'(STACK_DEPTH))
                            err_reg <= ST_OVERFLOW;
                        else
                            ocnt_reg <= ocnt_reg + 1'b1;
                    end
                    K_LPAR:
                    begin
                        handled_reg <= 1'b1;
                        if (pcnt_reg == CNT_W'(STACK_DEPTH))
                            err_reg <= ST_OVERFLOW;
                        else
                            pcnt_reg <= pcnt_reg + 1'b1;
                    end
                    K_RPAR:
                        if (pcnt_reg == '0)
                        begin
                            err_reg <= ST_MALFORMED;
                            handled_reg <= 1'b1;
                        end
                        else if (top_op == OP_PAREN)
                        begin
                            pcnt_reg <= pcnt_reg - 1'b1;
                            handled_reg <= 1'b1;
                        end
                        else if (!can_reduce)
                        begin
                            err_reg <= ST_MALFORMED;
                            handled_reg <= 1'b1;
                        end
                    K_OPER:
                        if (pcnt_reg != '0 && top_op != OP_PAREN
                            && prec(top_op) >= prec(tok_reg.op))
                        begin
                            if (!can_reduce)
                            begin
                                err_reg <= ST_MALFORMED;
                                handled_reg <= 1'b1;
                            end
                        end
                        else
                        begin
                            handled_reg <= 1'b1;
                            if (pcnt_reg == CNT_W'(STACK_DEPTH))
                                err_reg <= ST_OVERFLOW;
                            else
                                pcnt_reg <= pcnt_reg + 1'b1;
                        end
                    default:
                        handled_reg <= 1'b1;
                endcase
            end

            if ((state_reg == S_DISPATCH || state_reg == S_FLUSH) && state_next == S_REDUCE)
            begin
                pcnt_reg <= pcnt_reg - 1'b1;
                ocnt_reg <= ocnt_reg - 2'd2;
            end
            if (state_reg == S_REDUCE && rop_reg == OP_DIV && b_reg == '0)
                err_reg <= ST_DIVZERO;
            if (state_reg == S_WRITE)
                ocnt_reg <= ocnt_reg + 1'b1;

            if (state_reg == S_FLUSH && state_next == S_EMIT)
            begin
                if (pcnt_reg != '0 && err_reg == ST_OK)
                    err_reg <= ST_MALFORMED;
            end

            if (state_reg == S_EMIT && !out_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= err_flush;
                out_value_reg  <= (err_flush == ST_OK) ? opnd_mem[0] : 32'd0;
                ocnt_reg       <= '0;
                pcnt_reg       <= '0;
                err_reg        <= ST_OK;
            end
        end
    end

endmodule

`default_nettype wire

FILE: bench/tb.sv
// testbench for infix_expression_evaluator_core: random and directed expressions,
// checked against an in-bench two-stack evaluator; depends on iee_pkg and the core
`timescale 1ns / 100ps
`default_nettype none

module tb;
    import iee_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_t;

    typedef struct packed {
        logic [31:0] value;
        status_t     status;
    } answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // [7:0] ch
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // [31:0] value, [33:32] status, zero fill

    infix_expression_evaluator_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // evaluator state
    logic [31:0] num_stk [STACK_DEPTH];
    op_t         op_stk  [STACK_DEPTH];
    int          num_cnt, op_cnt;
    status_t     err;

    char_t   pending_chars[$];
    answer_t expected_answers[$];
    int      mismatches = 0;
    int      answers_seen = 0;
    int      chars_sent = 0;
    bit      hold_sink = 1'b0;
    bit      done_sending = 1'b0;

    function automatic void set_err(status_t s);
        if (err == ST_OK)
            err = s;
    endfunction

    function automatic int rank(op_t o);
        return (o == OP_MUL || o == OP_DIV) ? 2 : 1;
    endfunction

    function automatic void apply_top();
        op_t         o;
        logic [31:0] a, b, r, ma, mb, q;
        if (op_cnt == 0 || num_cnt < 2) begin
            set_err(ST_MALFORMED);
            return;
        end
        o = op_stk[op_cnt - 1];
        if (o == OP_PAREN) begin
            set_err(ST_MALFORMED);
            return;
        end
        op_cnt--;
        b = num_stk[num_cnt - 1];
        a = num_stk[num_cnt - 2];
        num_cnt -= 2;
        case (o)
            OP_ADD:  r = a + b;
            OP_SUB:  r = a - b;
            OP_MUL:  r = a * b;
            default:
            begin
                if (b == 0) begin
                    set_err(ST_DIVZERO);
                    return;
                end
                ma = a[31] ? -a : a;
                mb = b[31] ? -b : b;
                q = ma / mb;
                r = (a[31] ^ b[31]) ? -q : q;
            end
        endcase
        num_stk[num_cnt] = r;
        num_cnt++;
    endfunction

    function automatic void push_op(op_t o);
        if (op_cnt >= STACK_DEPTH)
            set_err(ST_OVERFLOW);
        else begin
            op_stk[op_cnt] = o;
            op_cnt++;
        end
    endfunction

    function automatic void take_char(logic [7:0] c);
        op_t o;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            if (num_cnt >= STACK_DEPTH)
                set_err(ST_OVERFLOW);
            else begin
                num_stk[num_cnt] = {28'd0, 4'(c - CH_ZERO)};
                num_cnt++;
            end
            return;
        end
        if (c == CH_LPAR) begin
            push_op(OP_PAREN);
            return;
        end
        if (c == CH_RPAR) begin
            while (err == ST_OK) begin
                if (op_cnt == 0) begin
                    set_err(ST_MALFORMED);
                    return;
                end
                if (op_stk[op_cnt - 1] == OP_PAREN) begin
                    op_cnt--;
                    return;
                end
                apply_top();
            end
            return;
        end
        case (c)
            CH_PLUS:  o = OP_ADD;
            CH_MINUS: o = OP_SUB;
            CH_STAR:  o = OP_MUL;
            CH_SLASH: o = OP_DIV;
            default:  return;
        endcase
        while (err == ST_OK && op_cnt > 0) begin
            if (op_stk[op_cnt - 1] == OP_PAREN || rank(op_stk[op_cnt - 1]) < rank(o))
                break;
            apply_top();
        end
        if (err == ST_OK)
            push_op(o);
    endfunction

    function automatic void evaluate_char(char_t it);
        answer_t ans;
        if (err == ST_OK)
            take_char(it.ch);
        if (!it.last)
            return;
        while (err == ST_OK && op_cnt > 0)
            apply_top();
        if (err == ST_OK && num_cnt != 1)
            set_err(ST_MALFORMED);
        ans.status = err;
        ans.value  = (err == ST_OK) ? num_stk[0] : 32'd0;
        expected_answers.push_back(ans);
        num_cnt = 0;
        op_cnt  = 0;
        err     = ST_OK;
    endfunction

    // stimulus builders
    function automatic void add_text(string s);
        char_t it;
        for (int i = 0; i < s.len(); i++) begin
            it.ch   = s[i];
            it.last = (i == s.len() - 1);
            pending_chars.push_back(it);
        end
    endfunction

    function automatic logic [7:0] any_oper();
        case ($urandom_range(0, 3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    // well-formed expression, occasionally nested
    function automatic string build_expr(int depth);
        string s;
        int    terms;
        terms = $urandom_range(1, 4);
        s = "";
        for (int i = 0; i < terms; i++) begin
            if (i > 0)
                s = {s, string'(any_oper())};
            if (depth < 3 && $urandom_range(0, 4) == 0)
                s = {s, "(", build_expr(depth + 1), ")"};
            else
                s = {s, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
        end
        return s;
    endfunction

    function automatic void add_noise();
        int    n;
        string s;
        logic [7:0] c;
        n = $urandom_range(1, 20);
        s = "";
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 4))
                0:       c = 8'($urandom_range(0, 255));
                1:       c = any_oper();
                2:       c = $urandom_range(0, 1) ? CH_LPAR : CH_RPAR;
                default: c = 8'(CH_ZERO + $urandom_range(0, 9));
            endcase
            s = {s, string'(c)};
        end
        add_text(s);
    endfunction

    // driver
    int send_wait = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                chars_sent++;
                evaluate_char('{ch: s_tdata, last: s_tlast});
            end
            if (!s_tvalid || s_tready) begin
                if (send_wait > 0) begin
                    send_wait <= send_wait - 1;
                    s_tvalid  <= 1'b0;
                end else if (pending_chars.size() > 0 && !done_sending) begin
                    char_t it;
                    it = pending_chars.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tdata   <= it.ch;
                    s_tlast   <= it.last;
                    send_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor with random receiver stalls
    int sink_wait = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                answer_t want;
                answers_seen++;
                if (expected_answers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", m_tdata);
                end else begin
                    want = expected_answers.pop_front();
                    if (m_tdata[31:0] !== want.value || m_tdata[33:32] !== want.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected value %0d status %0d, got %0d / %0d",
                                     $signed(want.value), want.status,
                                     $signed(m_tdata[31:0]), m_tdata[33:32]);
                    end
                end
                sink_wait = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
            end
            if (hold_sink)
                m_tready <= 1'b0;
            else if (sink_wait > 0) begin
                sink_wait--;
                m_tready <= 1'b0;
            end else
                m_tready <= 1'b1;
        end
    end

    task automatic wait_drained();
        while (pending_chars.size() > 0 || s_tvalid || expected_answers.size() > 0)
            @(posedge clk);
    endtask

    initial begin
        string deep;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        add_text("9*9-8/2");
        add_text("(1+2)*3");
        add_text("8-3-2");
        add_text("8/2/2");
        add_text("7/0");
        add_text("0-7/2");
        add_text("1+)");
        add_text("(5");
        add_text("");
        add_text("12");
        add_text("+");
        add_text("x");
        add_text("3 + 4");
        deep = "";
        for (int i = 0; i < 17; i++)
            deep = {deep, "9"};
        add_text(deep);
        deep = "";
        for (int i = 0; i < 17; i++)
            deep = {deep, "("};
        add_text({deep, "1"});
        // wraparound: 9^10 grows past the signed 32-bit range
        add_text("9*9*9*9*9*9*9*9*9*9");
        add_text("(0-9*9*9*9*9*9*9*9*9*9-2)/(0-1)");
        pending_chars.push_back('{ch: 8'hFF, last: 1'b1});
        pending_chars.push_back('{ch: 8'h00, last: 1'b0});
        pending_chars.push_back('{ch: 8'h35, last: 1'b1});
        wait_drained();

        // receiver holds off while the sender keeps offering
        for (int i = 0; i < 20; i++)
            add_text(build_expr(0));
        hold_sink = 1'b1;
        repeat (400) @(posedge clk);
        hold_sink = 1'b0;
        wait_drained();

        while (chars_sent < 1400) begin
            if ($urandom_range(0, 7) == 0)
                add_noise();
            else
                add_text(build_expr(0));
            while (pending_chars.size() > 0)
                @(posedge clk);
        end
        wait_drained();
        repeat (200) @(posedge clk);
        done_sending = 1'b1;

        $display("sent %0d characters, checked %0d results", chars_sent, answers_seen);
        $display("covered nesting, precedence, wraparound, divide by zero, overflow, junk");
        if (mismatches == 0 && expected_answers.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
